/* rtl/wsdf_pkg.sv */
// Shared types and codes for the WebSocket frame deframer.
package wsdf_pkg;

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXT,
    PH_MASK,
    PH_PAY
  } phase_e;

  localparam logic [3:0] OP_CONT = 4'h0;
  localparam logic [3:0] OP_TEXT = 4'h1;
  localparam logic [3:0] OP_BIN  = 4'h2;
  localparam logic [3:0] OP_PING = 4'h9;
  localparam logic [3:0] OP_PONG = 4'hA;

  localparam logic [6:0] LEN_MAX_SHORT = 7'd125;
  localparam logic [6:0] LEN_EXT16     = 7'd126;

  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

  localparam logic [3:0] ST_PING       = 4'd8;
  localparam logic [3:0] ST_PONG       = 4'd9;
  localparam logic [3:0] ST_ERROR      = 4'd10;
  localparam logic [3:0] ST_INCOMPLETE = 4'd11;
  localparam logic [3:0] ST_OVERSIZE   = 4'd12;

  localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd65535;

endpackage

/* rtl/websocket_frame_deframer.sv */
// WebSocket frame deframer: parses received bytes into unmasked payload and frame status.
// Output: each accepted byte's result is registered, reaching the master side the next cycle.
// Throughput: one byte per cycle unless a held result stalls; the header, length and payload
// counters all update in the cycle a byte is taken; a single output register holds results.
// Reset: asynchronous, active low; parsing waits for a frame header and max_payload is 65535.
module websocket_frame_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i,      // max_payload
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // in_byte
  input  logic        s_axis_tlast_i,  // buffer_end
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,  // out_byte [7:0], status [11:8], zero fill
  output logic [1:0]  m_axis_tuser_o   // byte_valid [0], status_valid [1]
);
  import wsdf_pkg::*;

  phase_e      phase_q, phase_d;
  logic [3:0]  opcode_q, opcode_d;
  logic        fin_q, fin_d;
  logic        masked_q, masked_d;
  logic [3:0]  ext_cnt_q, ext_cnt_d;
  logic [63:0] len_q, len_d;
  logic [63:0] rem_len_q, rem_len_d;
  logic [31:0] key_q, key_d;
  logic [1:0]  lane_q, lane_d;
  logic [1:0]  seen_q, seen_d;
  logic        discard_q, discard_d;
  logic [31:0] max_q;

  logic        out_valid_q, out_valid_d;
  logic        out_bv_q;
  logic [7:0]  out_byte_q;
  logic        out_sv_q;
  logic [3:0]  out_st_q;

  logic        in_acc;
  logic [7:0]  b;
  logic        last;
  logic [1:0]  seen_inc;
  logic        oversize;
  logic        is_data;
  logic [3:0]  ext_cnt_dec;
  logic [63:0] len_shift;
  logic        frame_end;
  logic [3:0]  end_st;
  logic [7:0]  key_byte;
  logic        res_bv;
  logic [7:0]  res_byte;
  logic        res_sv;
  logic [3:0]  res_st;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign b               = s_axis_tdata_i;
  assign last            = s_axis_tlast_i;

  assign seen_inc    = (seen_q == 2'd3) ? 2'd3 : seen_q + 2'd1;
  assign oversize    = (|len_q[63:32]) || (len_q[31:0] > max_q);
  assign is_data     = (opcode_q <= OP_BIN);
  assign ext_cnt_dec = (ext_cnt_q != 4'd0) ? ext_cnt_q - 4'd1 : 4'd0;
  assign len_shift   = {len_q[55:0], b};

  // Status of a frame that ends on this byte.
  always_comb begin
    if (last && seen_inc != 2'd3) begin
      end_st = ST_ERROR;
    end else if (oversize) begin
      end_st = ST_OVERSIZE;
    end else if (opcode_q == OP_PING) begin
      end_st = ST_PING;
    end else if (opcode_q == OP_PONG) begin
      end_st = ST_PONG;
    end else if (!is_data) begin
      end_st = ST_ERROR;
    end else begin
      end_st = {1'b0, opcode_q == OP_BIN, !last, !fin_q};
    end
  end

  // Next state of the frame parser.
  always_comb begin
    phase_d   = phase_q;
    opcode_d  = opcode_q;
    fin_d     = fin_q;
    masked_d  = masked_q;
    ext_cnt_d = ext_cnt_q;
    len_d     = len_q;
    rem_len_d = rem_len_q;
    key_d     = key_q;
    lane_d    = lane_q;
    seen_d    = seen_q;
    discard_d = discard_q;
    frame_end = 1'b0;
    if (in_acc) begin
      if (discard_q) begin
        if (last) begin
          discard_d = 1'b0;
          phase_d   = PH_HDR0;
          seen_d    = 2'd0;
        end
      end else begin
        seen_d = seen_inc;
        unique case (phase_q)
          PH_HDR0: begin
            opcode_d  = b[3:0];
            fin_d     = b[7];
            len_d     = '0;
            rem_len_d = '0;
            key_d     = '0;
            lane_d    = 2'd0;
            ext_cnt_d = 4'd0;
            phase_d   = PH_HDR1;
          end
          PH_HDR1: begin
            masked_d = b[7];
            if (b[6:0] <= LEN_MAX_SHORT) begin
              len_d     = {57'd0, b[6:0]};
              rem_len_d = {57'd0, b[6:0]};
              if (b[7]) begin
                ext_cnt_d = KEY_BYTES;
                phase_d   = PH_MASK;
              end else begin
                lane_d    = 2'd0;
                phase_d   = PH_PAY;
                frame_end = (b[6:0] == 7'd0);
              end
            end else begin
              ext_cnt_d = (b[6:0] == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
              phase_d   = PH_EXT;
            end
          end
          PH_EXT: begin
            len_d     = len_shift;
            rem_len_d = len_shift;
            ext_cnt_d = ext_cnt_dec;
            if (ext_cnt_dec == 4'd0) begin
              if (masked_q) begin
                ext_cnt_d = KEY_BYTES;
                phase_d   = PH_MASK;
              end else begin
                lane_d    = 2'd0;
                phase_d   = PH_PAY;
                frame_end = (len_shift == 64'd0);
              end
            end
          end
          PH_MASK: begin
            key_d     = {key_q[23:0], b};
            ext_cnt_d = ext_cnt_dec;
            if (ext_cnt_dec == 4'd0) begin
              lane_d    = 2'd0;
              phase_d   = PH_PAY;
              frame_end = (len_q == 64'd0);
            end
          end
          PH_PAY: begin
            lane_d    = lane_q + 2'd1;
            rem_len_d = rem_len_q - 64'd1;
            frame_end = (rem_len_q == 64'd1);
          end
          default: begin
            phase_d = PH_HDR0;
          end
        endcase
        if (frame_end) begin
          phase_d = PH_HDR0;
          seen_d  = 2'd0;
          // Control, error and oversize outcomes drop the rest of the buffer.
          if (!last && end_st >= ST_PING) begin
            discard_d = 1'b1;
          end
        end else if (last) begin
          phase_d = PH_HDR0;
          seen_d  = 2'd0;
        end
      end
    end
  end

  always_comb begin
    case (lane_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  // Result of the beat being accepted.
  always_comb begin
    res_bv   = !discard_q && (phase_q == PH_PAY) && is_data && !oversize;
    res_byte = res_bv ? (b ^ (masked_q ? key_byte : 8'd0)) : 8'd0;
    res_sv   = !discard_q && (frame_end || last);
    if (!res_sv) begin
      res_st = 4'd0;
    end else if (frame_end) begin
      res_st = end_st;
    end else begin
      res_st = (seen_inc != 2'd3) ? ST_ERROR : ST_INCOMPLETE;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_acc) begin
      out_valid_d = res_bv || res_sv;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HDR0;
      opcode_q    <= 4'd0;
      fin_q       <= 1'b0;
      masked_q    <= 1'b0;
      ext_cnt_q   <= 4'd0;
      len_q       <= '0;
      rem_len_q   <= '0;
      key_q       <= '0;
      lane_q      <= 2'd0;
      seen_q      <= 2'd0;
      discard_q   <= 1'b0;
      max_q       <= MAX_PAYLOAD_RESET;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      opcode_q    <= opcode_d;
      fin_q       <= fin_d;
      masked_q    <= masked_d;
      ext_cnt_q   <= ext_cnt_d;
      len_q       <= len_d;
      rem_len_q   <= rem_len_d;
      key_q       <= key_d;
      lane_q      <= lane_d;
      seen_q      <= seen_d;
      discard_q   <= discard_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        max_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_bv_q   <= res_bv;
      out_byte_q <= res_byte;
      out_sv_q   <= res_sv;
      out_st_q   <= res_st;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'd0, out_st_q, out_byte_q};
  assign m_axis_tuser_o  = {out_sv_q, out_bv_q};

endmodule
